// ===== rtl/core/fdl_pkg.sv =====
package fdl_pkg;

	localparam logic [1:0] REQ_RECORD = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] fault_code;
		logic [15:0] fault_source;
		logic [31:0] time_us;
		logic [3:0]  read_index;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic        merged;
		logic [15:0] entry_code;
		logic [15:0] entry_source;
		logic [31:0] entry_first_us;
		logic [31:0] entry_last_us;
		logic [31:0] entry_hits;
		logic [4:0]  fill_count;
		logic        overflow_flag;
	} rsp_t;

	// one log slot as stored in the entry memory
	typedef struct packed {
		logic [15:0] code;
		logic [15:0] source;
		logic [31:0] first_us;
		logic [31:0] last_us;
		logic [31:0] hits;
	} entry_t;

endpackage

// ===== rtl/core/fdl_mem.sv =====
module fdl_mem #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  fdl_pkg::entry_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output fdl_pkg::entry_t          rdata
);
	import fdl_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/fdl_ctrl.sv =====
module fdl_ctrl #(
	parameter int LOG_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  fdl_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output fdl_pkg::rsp_t                rsp,
	output logic                         mem_we,
	output logic [$clog2(LOG_DEPTH)-1:0] mem_waddr,
	output fdl_pkg::entry_t              mem_wdata,
	output logic [$clog2(LOG_DEPTH)-1:0] mem_raddr,
	input  fdl_pkg::entry_t              mem_rdata
);
	import fdl_pkg::*;

	localparam int AW = $clog2(LOG_DEPTH);
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int SW = ((AW > 4) ? AW : 4) + 1;
	localparam int TW = (CW > 4) ? CW : 4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_READ,
		S_FINISH
	} state_t;

	state_t        state_q;
	req_t          req_q;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic [CW-1:0] filled_q;
	logic [AW-1:0] oldest_q;
	logic          ovf_q;
	logic [CW-1:0] cmp_q;
	logic [AW-1:0] iss_q;
	logic          wr_pend_q;
	logic [AW-1:0] wr_addr_q;
	entry_t        wr_ent_q;

	logic          accept;
	logic          fire_fin;
	logic          full;
	logic [AW-1:0] miss_addr;
	logic [SW-1:0] phys_sum;
	logic [AW-1:0] read_phys;
	logic          read_hit;
	logic          match;
	logic          last_cmp;
	logic [CW-1:0] filled_d;
	logic [AW-1:0] oldest_d;
	logic          ovf_d;
	entry_t        new_ent;
	entry_t        merged_ent;
	rsp_t          res_d;
	rsp_t          rsp_d;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		wrap_inc = (a == AW'(LOG_DEPTH - 1)) ? '0 : a + 1'b1;
	endfunction

	assign accept   = req_valid && req_ready;
	assign fire_fin = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready);
	assign full     = (filled_q == CW'(LOG_DEPTH));
	assign miss_addr = full ? oldest_q : filled_q[AW-1:0];

	// logical to physical slot: one compare and subtract, the sum stays below twice the depth
	assign phys_sum  = SW'(oldest_q) + SW'(req.read_index);
	assign read_phys = (phys_sum >= SW'(LOG_DEPTH)) ? AW'(phys_sum - SW'(LOG_DEPTH))
		: AW'(phys_sum);
	assign read_hit  = TW'(req.read_index) < TW'(filled_q);

	assign match    = (mem_rdata.code == req_q.fault_code) &&
		(mem_rdata.source == req_q.fault_source);
	assign last_cmp = (cmp_q == filled_q - 1'b1);

	assign new_ent = '{code: req.fault_code, source: req.fault_source,
		first_us: req.time_us, last_us: req.time_us, hits: 32'd1};

	always_comb begin
		merged_ent         = mem_rdata;
		merged_ent.last_us = req_q.time_us;
		if (mem_rdata.hits != HITS_MAX) begin
			merged_ent.hits = mem_rdata.hits + 32'd1;
		end
	end

	always_comb begin
		filled_d = filled_q;
		oldest_d = oldest_q;
		ovf_d    = ovf_q;
		case (req_q.req_type)
			REQ_RECORD: begin
				if (!res_q.merged) begin
					if (full) begin
						oldest_d = wrap_inc(oldest_q);
						ovf_d    = 1'b1;
					end else begin
						filled_d = filled_q + 1'b1;
					end
				end
			end
			REQ_CLEAR: begin
				filled_d = '0;
				oldest_d = '0;
				ovf_d    = 1'b0;
			end
			default: ;
		endcase
	end

	// build the result as the request moves through its steps
	always_comb begin
		res_d = res_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d    = '0;
					res_d.ok = (req.req_type == REQ_RECORD) || (req.req_type == REQ_CLEAR);
				end
			end
			S_SEARCH: begin
				if (match) begin
					res_d.merged = 1'b1;
				end
			end
			S_READ: begin
				res_d.ok             = 1'b1;
				res_d.entry_code     = mem_rdata.code;
				res_d.entry_source   = mem_rdata.source;
				res_d.entry_first_us = mem_rdata.first_us;
				res_d.entry_last_us  = mem_rdata.last_us;
				res_d.entry_hits     = mem_rdata.hits;
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp_d               = res_q;
		rsp_d.fill_count    = 5'(filled_d);
		rsp_d.overflow_flag = ovf_d;
	end

	always_comb begin
		case (state_q)
			S_IDLE:   mem_raddr = (req.req_type == REQ_READ) ? read_phys : oldest_q;
			S_SEARCH: mem_raddr = wrap_inc(iss_q);
			default:  mem_raddr = iss_q;
		endcase
	end

	assign mem_we    = fire_fin && wr_pend_q;
	assign mem_waddr = wr_addr_q;
	assign mem_wdata = wr_ent_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		iss_q <= mem_raddr;
		res_q <= res_d;
		if (accept) begin
			req_q     <= req;
			wr_pend_q <= (req.req_type == REQ_RECORD) && (filled_q == '0);
			wr_addr_q <= miss_addr;
			wr_ent_q  <= new_ent;
			cmp_q     <= '0;
		end
		if (state_q == S_SEARCH) begin
			cmp_q <= cmp_q + 1'b1;
			if (match) begin
				wr_pend_q <= 1'b1;
				wr_addr_q <= iss_q;
				wr_ent_q  <= merged_ent;
			end else if (last_cmp) begin
				wr_pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			filled_q    <= '0;
			oldest_q    <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (fire_fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_RECORD && filled_q != '0) begin
							state_q <= S_SEARCH;
						end else if (req.req_type == REQ_READ && read_hit) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SEARCH: begin
					// stop at the first match or after the newest entry
					if (match || last_cmp) begin
						state_q <= S_FINISH;
					end
				end
				S_READ: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (fire_fin) begin
						rsp_q    <= rsp_d;
						filled_q <= filled_d;
						oldest_q <= oldest_d;
						ovf_q    <= ovf_d;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/dedup_ring_fault_log.sv =====
// Deduplicating circular fault log.
// Requests enter on req (req_valid/req_ready), one result per request leaves
// on rsp (rsp_valid/rsp_ready). A record request scans the filled entries,
// oldest first, one entry a cycle out of the entry memory; a match bumps the
// hit count (saturating) and the last timestamp, otherwise a new entry is
// written, overwriting the oldest one and setting the sticky overflow flag
// when the log is full. A read request returns the entry at a logical index
// counted from the oldest; clear empties the log.
// The scan length is set by the single read port of the entry memory, one
// compare per cycle. One request is in flight at a time; the next one is
// taken the cycle after the result is registered. req_ready is high
// whenever the sequencer is idle, even while an earlier result waits in the
// output register. A stalled receiver holds the finished result, and the
// next request waits in its final step until that result is taken.
// Reset empties the log and clears the overflow flag at once; entry contents
// are never cleared, only entries below the fill count are ever read.
module dedup_ring_fault_log #(
	parameter int LOG_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fdl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fdl_pkg::rsp_t rsp
);
	import fdl_pkg::*;

	localparam int AW = $clog2(LOG_DEPTH);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_wdata;
	entry_t        mem_rdata;

	fdl_ctrl #(
		.LOG_DEPTH(LOG_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	fdl_mem #(
		.DEPTH(LOG_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== rtl/core/fdl_checker.sv =====
module fdl_sva (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input fdl_pkg::rsp_t rsp
);
	import fdl_pkg::*;

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> !rsp.merged && rsp.entry_code == '0 &&
		rsp.entry_source == '0 && rsp.entry_first_us == '0 &&
		rsp.entry_last_us == '0 && rsp.entry_hits == '0)
		else $error("failed request carries entry data");

	a_merge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.merged |-> rsp.ok && rsp.entry_hits == '0)
		else $error("merged flag on a non-record result");

	a_read_hits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ok && rsp.entry_hits != '0 |-> !rsp.merged &&
		rsp.entry_first_us <= rsp.entry_last_us || rsp.entry_hits != 32'd1)
		else $error("single-hit entry with last time before first time");

endmodule

bind dedup_ring_fault_log fdl_sva u_fdl_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== test/fdl_checker.sv =====
`timescale 1ns / 100ps

module fdl_checker #(
	parameter int LOG_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  fdl_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  fdl_pkg::rsp_t rsp,
	output int            fail_count,
	output int            outstanding
);
	import fdl_pkg::*;

	entry_t     log_slot [LOG_DEPTH];
	logic [4:0] log_fill;
	logic [3:0] log_oldest;
	logic       log_overflow;
	rsp_t       awaited_rsp [$];

	// Apply one request to the shadow log and return the result it should produce.
	function automatic rsp_t log_apply(req_t r);
		rsp_t       o;
		logic [3:0] p;
		logic       hit;
		o = '0;
		hit = 1'b0;
		p = '0;
		case (r.req_type)
			REQ_RECORD: begin
				o.ok = 1'b1;
				// search oldest first, first match wins
				for (int i = 0; i < LOG_DEPTH; i++) begin
					if (!hit && i < log_fill) begin
						p = log_oldest + 4'(i);
						if (log_slot[p].code == r.fault_code &&
						    log_slot[p].source == r.fault_source) begin
							hit = 1'b1;
							if (log_slot[p].hits != HITS_MAX)
								log_slot[p].hits = log_slot[p].hits + 32'd1;
							log_slot[p].last_us = r.time_us;
						end
					end
				end
				if (!hit) begin
					if (log_fill < LOG_DEPTH) begin
						p = log_fill[3:0];
						log_fill = log_fill + 5'd1;
					end else begin
						// full: overwrite the oldest entry
						p = log_oldest;
						log_oldest = log_oldest + 4'd1;
						log_overflow = 1'b1;
					end
					log_slot[p].code = r.fault_code;
					log_slot[p].source = r.fault_source;
					log_slot[p].first_us = r.time_us;
					log_slot[p].last_us = r.time_us;
					log_slot[p].hits = 32'd1;
				end
				o.merged = hit;
			end
			REQ_READ: begin
				if ({1'b0, r.read_index} < log_fill) begin
					p = log_oldest + r.read_index;
					o.ok = 1'b1;
					o.entry_code = log_slot[p].code;
					o.entry_source = log_slot[p].source;
					o.entry_first_us = log_slot[p].first_us;
					o.entry_last_us = log_slot[p].last_us;
					o.entry_hits = log_slot[p].hits;
				end
			end
			REQ_CLEAR: begin
				log_fill = '0;
				log_oldest = '0;
				log_overflow = 1'b0;
				o.ok = 1'b1;
			end
			default: ;
		endcase
		o.fill_count = log_fill;
		o.overflow_flag = log_overflow;
		return o;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			log_fill = '0;
			log_oldest = '0;
			log_overflow = 1'b0;
			awaited_rsp.delete();
			outstanding <= 0;
		end else begin
			// a result accepted now always belongs to an earlier request
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					fail_count++;
					$display("%0t: no result expected, got %p", $time, rsp);
				end else begin
					want = awaited_rsp.pop_front();
					check_field("ok", want.ok, rsp.ok);
					check_field("merged", want.merged, rsp.merged);
					check_field("entry_code", want.entry_code, rsp.entry_code);
					check_field("entry_source", want.entry_source, rsp.entry_source);
					check_field("entry_first_us", want.entry_first_us, rsp.entry_first_us);
					check_field("entry_last_us", want.entry_last_us, rsp.entry_last_us);
					check_field("entry_hits", want.entry_hits, rsp.entry_hits);
					check_field("fill_count", want.fill_count, rsp.fill_count);
					check_field("overflow_flag", want.overflow_flag, rsp.overflow_flag);
				end
			end
			if (req_valid && req_ready)
				awaited_rsp.push_back(log_apply(req));
			outstanding <= awaited_rsp.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import fdl_pkg::*;

	localparam int         DEPTH = 16;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         PHASE_ITEMS = 374;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;
	int    fail_count;
	int    outstanding;

	int    send_idle_pct = 12;
	int    rsp_idle_pct = 46;

	logic [15:0] pool_code [20];
	logic [15:0] pool_src [20];

	dedup_ring_fault_log #(
		.LOG_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	fdl_checker #(
		.LOG_DEPTH(DEPTH)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
	end

	function automatic req_t req_of(logic [1:0] kind, logic [15:0] code, logic [15:0] src,
	                                logic [31:0] t, logic [3:0] idx);
		req_t r;
		r.req_type = kind;
		r.fault_code = code;
		r.fault_source = src;
		r.time_us = t;
		r.read_index = idx;
		return r;
	endfunction

	// Mostly records drawn from a small pool so entries merge and the log wraps.
	function automatic req_t draw_req();
		req_t r;
		int   roll;
		int   k;
		r = req_of(REQ_READ, 16'($urandom), 16'($urandom), $urandom, 4'($urandom_range(0, 15)));
		roll = $urandom_range(0, 99);
		if (roll < 58) begin
			r.req_type = REQ_RECORD;
			if ($urandom_range(0, 99) < 75) begin
				k = $urandom_range(0, 19);
				r.fault_code = pool_code[k];
				r.fault_source = pool_src[k];
			end
		end else if (roll < 95) begin
			r.req_type = REQ_READ;
		end else if (roll < 97) begin
			r.req_type = REQ_CLEAR;
		end else begin
			r.req_type = REQ_UNKNOWN;
		end
		return r;
	endfunction

	task automatic send(req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	// hold off new requests until every result is back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		for (int k = 0; k < 20; k++) begin
			pool_code[k] = (k >= 10) ? pool_code[k - 10] : 16'($urandom);
			pool_src[k] = 16'($urandom);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(req_of(REQ_READ, 16'h0, 16'h0, 32'h0, 4'd0));
		send(req_of(REQ_UNKNOWN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF));
		send(req_of(REQ_RECORD, 16'h0000, 16'h0000, 32'h0000_0000, 4'd0));
		send(req_of(REQ_RECORD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'd0));
		send(req_of(REQ_RECORD, 16'h0000, 16'hFFFF, 32'h0000_0007, 4'd0));
		send(req_of(REQ_RECORD, 16'h0000, 16'h0000, 32'h0000_0005, 4'd0));
		send(req_of(REQ_READ, 16'h0, 16'h0, 32'h0, 4'd0));
		send(req_of(REQ_READ, 16'h0, 16'h0, 32'h0, 4'd3));
		send(req_of(REQ_CLEAR, 16'h0, 16'h0, 32'h0, 4'd0));
		// fill the log, then one more to force an overwrite
		for (int i = 0; i <= DEPTH; i++)
			send(req_of(REQ_RECORD, 16'h0100 + 16'(i), ~(16'h0100 + 16'(i)),
			            32'h8000_0000 + 32'(i), 4'd0));
		send(req_of(REQ_READ, 16'h0, 16'h0, 32'h0, 4'hF));
		send(req_of(REQ_RECORD, 16'h0101, ~16'h0101, 32'hFFFF_FFFE, 4'd0));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 12;
					rsp_idle_pct <= 46;
				end
				1: begin
					send_idle_pct = 46;
					rsp_idle_pct <= 12;
				end
				default: begin
					send_idle_pct = 0;
					rsp_idle_pct <= 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send(draw_req());
			drain();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("PASS dedup_ring_fault_log");
		else
			$display("FAIL dedup_ring_fault_log");
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL dedup_ring_fault_log");
		$finish;
	end

endmodule

// ===== dedup_ring_fault_log.f =====
rtl/core/fdl_pkg.sv
rtl/core/fdl_mem.sv
rtl/core/fdl_ctrl.sv
rtl/core/dedup_ring_fault_log.sv
rtl/core/fdl_checker.sv
test/fdl_checker.sv
test/tb_top.sv
